// File: hdl/bpfc_pkg.sv
// Constants, command codes and the frame length decode for the bootloader
// frame checker. No dependencies; used by boot_packet_framer_checker_unit.
`timescale 1ns / 1ps

package bpfc_pkg;

   localparam int BLOCK_COUNT = 128;
   localparam int BLOCK_BYTES = 1024;
   localparam int CHUNK_BYTES = 256;

   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] CMD_ERASE  = 8'h05;
   localparam logic [7:0] CMD_WRITE  = 8'h06;
   localparam logic [7:0] CMD_RESET  = 8'h07;
   localparam logic [7:0] CMD_SWAP   = 8'h08;
   localparam logic [7:0] CMD_VERIFY = 8'h0b;

   localparam logic [8:0] LEN_SHORT  = 9'd4;
   localparam logic [8:0] LEN_CTRL   = 9'd6;
   localparam logic [8:0] LEN_ERASE  = 9'd11;
   localparam logic [8:0] LEN_WRITE  = 9'd261;

   localparam logic [8:0] IDX_START  = 9'd0;
   localparam logic [8:0] IDX_CMD    = 9'd3;
   localparam logic [8:0] IDX_ARG    = 9'd4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_SUM = 2'd1,
      STATUS_UNKNOWN = 2'd2
   } status_type;

   function automatic logic [8:0] length_of(input logic [7:0] cmd);
      logic [8:0] len;
      unique case (cmd)
         CMD_ERASE:                     len = LEN_ERASE;
         CMD_WRITE:                     len = LEN_WRITE;
         CMD_VERIFY, CMD_SWAP, CMD_RESET: len = LEN_CTRL;
         default:                       len = LEN_SHORT;
      endcase
      return len;
   endfunction

endpackage

// File: hdl/boot_packet_framer_checker_unit.sv
// Bootloader frame checker: byte framing, checksum and flash control tracking.
// Depends on bpfc_pkg for command codes, lengths and the length decode.
`timescale 1ns / 1ps

// Usage:
//   req_ channel: one received serial byte per beat (req_rx_byte).
//   rsp_ channel: one beat per completed frame carrying status, command,
//   byte 4, the erase/write/reset strobes and the flash write address.
//   A frame starts with 0x01; other bytes in the start position are dropped.
//   Byte 3 selects the frame length; the last byte of a known command is the
//   8-bit sum of all earlier bytes.
// Throughput: one byte per cycle while no beat is held. Each byte passes
//   through one stage of decode, add and compare before the result register.
// Latency: the result beat appears on the cycle after the last frame byte
//   is accepted.
// Stall: the result register holds its beat while rsp_ready is low, and
//   req_ready drops with it, so no byte is taken until the beat leaves; a
//   byte is still taken in the cycle in which the held beat is taken.
// Reset: synchronous, active high; clears the frame position, sum, latches,
//   erase block, write enable and write offset, and empties the result
//   register.
module boot_packet_framer_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_arg_byte,
   output logic        rsp_erase_go,
   output logic        rsp_write_go,
   output logic [17:0] rsp_write_address,
   output logic        rsp_reset_request
);

   logic [8:0]  byte_index_ff, byte_index_in;
   logic [8:0]  frame_length_ff, frame_length_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  cmd_latch_ff, cmd_latch_in;
   logic [7:0]  arg_latch_ff, arg_latch_in;
   logic [7:0]  erase_block_ff, erase_block_in;
   logic        write_enabled_ff, write_enabled_in;
   logic [15:0] write_offset_ff, write_offset_in;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  command_ff;
   logic [7:0]  arg_byte_ff, arg_byte_in;
   logic        erase_go_ff, erase_go_in;
   logic        write_go_ff, write_go_in;
   logic [17:0] address_ff, address_in;
   logic        reset_req_ff, reset_req_in;

   logic        accept;
   logic        drop;
   logic        frame_end;
   logic        sum_match;
   logic        block_ok;
   logic        erase_ok;
   logic [7:0]  sum_cur;
   logic [17:0] base_address;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign block_ok     = {1'b0, erase_block_ff} < 9'(bpfc_pkg::BLOCK_COUNT);
   assign erase_ok     = {1'b0, arg_latch_ff} < 9'(bpfc_pkg::BLOCK_COUNT);
   assign base_address = 18'(18'(erase_block_ff) * 18'(bpfc_pkg::BLOCK_BYTES));

   always_comb begin
      drop            = 1'b0;
      frame_length_in = frame_length_ff;
      arg_latch_in    = arg_latch_ff;
      cmd_latch_in    = cmd_latch_ff;
      sum_cur         = running_sum_ff;

      if (byte_index_ff == bpfc_pkg::IDX_START) begin
         drop            = req_rx_byte != bpfc_pkg::START_BYTE;
         frame_length_in = bpfc_pkg::LEN_SHORT;
         arg_latch_in    = 8'd0;
         sum_cur         = 8'd0;
      end
      if (byte_index_ff == bpfc_pkg::IDX_CMD) begin
         cmd_latch_in    = req_rx_byte;
         frame_length_in = bpfc_pkg::length_of(req_rx_byte);
      end
      if (byte_index_ff == bpfc_pkg::IDX_ARG) begin
         arg_latch_in = req_rx_byte;
      end

      frame_end = !drop && !((byte_index_ff + 9'd1) < frame_length_in);
      sum_match = sum_cur == req_rx_byte;

      byte_index_in    = byte_index_ff;
      running_sum_in   = running_sum_ff;
      erase_block_in   = erase_block_ff;
      write_enabled_in = write_enabled_ff;
      write_offset_in  = write_offset_ff;
      status_in        = bpfc_pkg::STATUS_OK;
      arg_byte_in      = arg_latch_in;
      erase_go_in      = 1'b0;
      write_go_in      = 1'b0;
      address_in       = 18'd0;
      reset_req_in     = 1'b0;

      if (!drop && !frame_end) begin
         byte_index_in  = byte_index_ff + 9'd1;
         running_sum_in = sum_cur + req_rx_byte;
      end else if (frame_end) begin
         byte_index_in  = 9'd0;
         running_sum_in = 8'd0;
         priority if (frame_length_in == bpfc_pkg::LEN_SHORT) begin
            status_in   = bpfc_pkg::STATUS_UNKNOWN;
            arg_byte_in = 8'd0;
         end else if (!sum_match) begin
            status_in = bpfc_pkg::STATUS_BAD_SUM;
         end else begin
            unique case (cmd_latch_in)
               bpfc_pkg::CMD_ERASE: begin
                  erase_block_in = arg_latch_in;
                  if (erase_ok) begin
                     erase_go_in      = 1'b1;
                     write_enabled_in = 1'b1;
                     write_offset_in  = 16'd0;
                  end
               end
               bpfc_pkg::CMD_VERIFY: begin
                  write_enabled_in = 1'b0;
               end
               bpfc_pkg::CMD_WRITE: begin
                  address_in = base_address + 18'(write_offset_ff);
                  if (block_ok && write_enabled_ff) begin
                     write_go_in     = 1'b1;
                     write_offset_in = write_offset_ff + 16'(bpfc_pkg::CHUNK_BYTES);
                  end
               end
               bpfc_pkg::CMD_SWAP, bpfc_pkg::CMD_RESET: begin
                  reset_req_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= 9'd0;
         frame_length_ff  <= bpfc_pkg::LEN_SHORT;
         running_sum_ff   <= 8'd0;
         cmd_latch_ff     <= 8'd0;
         arg_latch_ff     <= 8'd0;
         erase_block_ff   <= 8'd0;
         write_enabled_ff <= 1'b0;
         write_offset_ff  <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept && !drop) begin
            byte_index_ff    <= byte_index_in;
            frame_length_ff  <= frame_length_in;
            running_sum_ff   <= running_sum_in;
            cmd_latch_ff     <= cmd_latch_in;
            arg_latch_ff     <= arg_latch_in;
            erase_block_ff   <= erase_block_in;
            write_enabled_ff <= write_enabled_in;
            write_offset_ff  <= write_offset_in;
         end
         if (accept && frame_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_end) begin
         status_ff    <= status_in;
         command_ff   <= cmd_latch_in;
         arg_byte_ff  <= arg_byte_in;
         erase_go_ff  <= erase_go_in;
         write_go_ff  <= write_go_in;
         address_ff   <= address_in;
         reset_req_ff <= reset_req_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_status  = status_ff;
   assign rsp_command       = command_ff;
   assign rsp_arg_byte      = arg_byte_ff;
   assign rsp_erase_go      = erase_go_ff;
   assign rsp_write_go      = write_go_ff;
   assign rsp_write_address = address_ff;
   assign rsp_reset_request = reset_req_ff;

endmodule
